### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the maze generator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge, skip while reset is high
`define HAK_ASSERT(LBL, CLK, RST, PROP, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (RST) PROP) else $error(MSG);

// check a property on every rising edge, reset included
`define HAK_ASSERT_ALWAYS(LBL, CLK, PROP, MSG) \
  LBL: assert property (@(posedge CLK) PROP) else $error(MSG);

`endif

### rtl/core/hak_pkg.sv
// ----------------------------------------------------------------------------
// Hunt-and-kill maze package
// Field widths, codes and shared types of the maze generator.
// ----------------------------------------------------------------------------
package hak_pkg;

  localparam int DEF_MAX_SIDE  = 16;
  localparam int SIDE_W        = 5;
  localparam int RAND_W        = 8;
  localparam int TILE_W        = 5;
  localparam int KIND_W        = 2;
  localparam int GRID_SIDE_MIN = 2;

  localparam logic [SIDE_W-1:0] DEF_GRID_SIDE = SIDE_W'(4);

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_WALK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GOAL  = 2'd2;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_RIGHT,
    DIR_LEFT
  } dir_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WALK,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_GATHER,
    ST_PICK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic has;
    dir_t sel;
  } pick_t;

endpackage

### rtl/core/hunt_and_kill_maze_generator.sv
// ----------------------------------------------------------------------------
// Hunt-and-kill maze generator: a start item runs a sweep over the visited memory.
// Walk step: up to four neighbor reads and a pick, then the tiles are emitted in order.
// Hunt: each scanned cell is read and checked; an unvisited one has its neighbors read.
// Reset (rst, synchronous) sets phase idle; the visited memory is cleared by
// the sweep of each start item, during which no item is taken.
// ----------------------------------------------------------------------------
module hunt_and_kill_maze_generator
  import hak_pkg::*;
#(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIDE_W-1:0] grid_side,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              func,
  input  logic [RAND_W-1:0] rand_value,
  output logic              tile_valid,
  input  logic              tile_ready,
  output logic [TILE_W-1:0] tile_x,
  output logic [TILE_W-1:0] tile_y,
  output logic [KIND_W-1:0] tile_kind,
  output logic              maze_done,
  output logic              last_of_run
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = ($clog2(MAX_SIDE + 1) > SIDE_W) ? $clog2(MAX_SIDE + 1) : SIDE_W;
  localparam int TSW   = (CW + 2 > TILE_W) ? CW + 2 : TILE_W;

  typedef struct packed {
    logic          ok;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } nbr_t;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(AW'(x) * AW'(MAX_SIDE) + AW'(y));
  endfunction

  function automatic logic [TILE_W-1:0] tile_of(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
    logic [TSW-1:0] s;
    s = TSW'(a) + TSW'(b) + TSW'(1);
    return s[TILE_W-1:0];
  endfunction

  function automatic nbr_t nbr_of(input dir_t k, input logic [CW-1:0] bx,
                                  input logic [CW-1:0] by, input logic [CW-1:0] n);
    logic [CW:0] nx;
    logic [CW:0] ny;
    logic        lo_ok;
    nbr_t        r;
    nx    = {1'b0, bx};
    ny    = {1'b0, by};
    lo_ok = 1'b1;
    unique case (k)
      DIR_UP: begin
        lo_ok = (by != '0);
        ny    = {1'b0, by} - 1'b1;
      end
      DIR_DOWN:  ny = {1'b0, by} + 1'b1;
      DIR_RIGHT: nx = {1'b0, bx} + 1'b1;
      DIR_LEFT: begin
        lo_ok = (bx != '0);
        nx    = {1'b0, bx} - 1'b1;
      end
    endcase
    r.ok = lo_ok && (nx < {1'b0, n}) && (ny < {1'b0, n});
    r.x  = nx[CW-1:0];
    r.y  = ny[CW-1:0];
    return r;
  endfunction

  state_t st, st_next;
  phase_t phase;

  logic [SIDE_W-1:0] side_cfg;
  logic [SW-1:0]     side_ext;
  logic [SW-1:0]     side_clamp;

  logic [CW-1:0] cur_x, cur_y, org_x, org_y;
  logic [CW-1:0] base_x, base_y, scan_x, scan_y;
  logic [CW-1:0] n_cells;
  logic [RAND_W-1:0] req_rand;
  logic          want_seen;
  logic [3:0]    mask;
  logic [2:0]    g_cnt;
  logic          pend;
  dir_t          pend_k;
  logic [AW-1:0] clr_addr;

  logic [TILE_W-1:0] res_x [3];
  logic [TILE_W-1:0] res_y [3];
  logic [KIND_W-1:0] res_kind [3];
  logic [1:0]        res_last;
  logic [1:0]        res_idx;

  logic          vis_mem [CELLS];
  logic          rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          mem_wd;

  logic  item_fire;
  logic  out_free;
  logic  scan_last;
  logic  adv;
  nbr_t  g_nbr;
  nbr_t  sel_nbr;
  pick_t pk;

  hak_pick u_pick (
    .mask       (mask),
    .rand_value (req_rand),
    .pick       (pk)
  );

  always_comb begin
    side_ext = SW'(side_cfg);
    if (side_ext < SW'(GRID_SIDE_MIN)) begin
      side_clamp = SW'(GRID_SIDE_MIN);
    end else if (side_ext > SW'(MAX_SIDE)) begin
      side_clamp = SW'(MAX_SIDE);
    end else begin
      side_clamp = side_ext;
    end
  end

  assign item_fire = item_valid && item_ready;
  assign out_free  = !tile_valid || tile_ready;
  assign g_nbr     = nbr_of(dir_t'(g_cnt[1:0]), base_x, base_y, n_cells);
  assign sel_nbr   = nbr_of(pk.sel, base_x, base_y, n_cells);
  assign scan_last = (scan_x == n_cells - 1'b1) && (scan_y == n_cells - 1'b1);
  assign adv       = ((st == ST_SCAN_CHK) && rd_data)
                  || ((st == ST_PICK) && want_seen && !pk.has);

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (item_fire) begin
          if (func == FUNC_START) begin
            st_next = ST_CLEAR;
          end else if (phase == PH_WALK) begin
            st_next = ST_GATHER;
          end
        end
      end
      ST_CLEAR: begin
        if (clr_addr == '0) st_next = ST_EMIT;
      end
      ST_GATHER: begin
        if (g_cnt == 3'd4) st_next = ST_PICK;
      end
      ST_PICK: begin
        if (pk.has) begin
          st_next = ST_EMIT;
        end else if (!want_seen) begin
          st_next = ST_SCAN_RD;
        end else if (scan_last) begin
          st_next = ST_EMIT;
        end else begin
          st_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: st_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!rd_data) begin
          st_next = ST_GATHER;
        end else if (scan_last) begin
          st_next = ST_EMIT;
        end else begin
          st_next = ST_SCAN_RD;
        end
      end
      ST_EMIT: begin
        if (out_free && (res_idx == res_last)) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    item_ready = (st == ST_IDLE);
    rd_en      = 1'b0;
    rd_addr    = addr_of(scan_x, scan_y);
    mem_we     = 1'b0;
    mem_wa     = clr_addr;
    mem_wd     = 1'b0;
    unique case (st)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = (clr_addr == '0);
      end
      ST_GATHER: begin
        rd_en   = (g_cnt != 3'd4) && g_nbr.ok;
        rd_addr = addr_of(g_nbr.x, g_nbr.y);
      end
      ST_PICK: begin
        mem_we = pk.has;
        mem_wa = want_seen ? addr_of(base_x, base_y) : addr_of(sel_nbr.x, sel_nbr.y);
        mem_wd = 1'b1;
      end
      ST_SCAN_RD: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) vis_mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= vis_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      phase      <= PH_IDLE;
      side_cfg   <= DEF_GRID_SIDE;
      cur_x      <= '0;
      cur_y      <= '0;
      org_x      <= '0;
      org_y      <= '0;
      clr_addr   <= '0;
      g_cnt      <= '0;
      pend       <= 1'b0;
      res_idx    <= '0;
      tile_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_we) side_cfg <= grid_side;

      if (st == ST_IDLE && item_fire) begin
        g_cnt <= '0;
        pend  <= 1'b0;
        if (func == FUNC_START) begin
          clr_addr <= AW'(CELLS - 1);
          phase    <= PH_WALK;
          cur_x    <= '0;
          cur_y    <= '0;
          org_x    <= '0;
          org_y    <= '0;
        end
      end

      if (st == ST_CLEAR) clr_addr <= clr_addr - 1'b1;

      if (st == ST_GATHER) begin
        g_cnt <= g_cnt + 3'd1;
        pend  <= (g_cnt != 3'd4) && g_nbr.ok;
      end

      if (st == ST_SCAN_CHK && !rd_data) begin
        g_cnt <= '0;
        pend  <= 1'b0;
      end

      if (st == ST_PICK && pk.has) begin
        if (want_seen) begin
          cur_x <= base_x;
          cur_y <= base_y;
          org_x <= base_x;
          org_y <= base_y;
        end else begin
          cur_x <= sel_nbr.x;
          cur_y <= sel_nbr.y;
        end
      end

      if (adv && scan_last) phase <= PH_DONE;

      if (st == ST_EMIT) begin
        if (out_free) res_idx <= res_idx + 2'd1;
      end else begin
        res_idx <= '0;
      end

      if (st == ST_EMIT && out_free) begin
        tile_valid <= 1'b1;
      end else if (tile_ready) begin
        tile_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_IDLE && item_fire) begin
      req_rand    <= rand_value;
      n_cells     <= CW'(side_clamp - 1'b1);
      base_x      <= cur_x;
      base_y      <= cur_y;
      want_seen   <= 1'b0;
      mask        <= '0;
      res_x[0]    <= TILE_W'(1);
      res_y[0]    <= TILE_W'(1);
      res_kind[0] <= KIND_START;
      res_last    <= 2'd0;
    end

    if (st == ST_GATHER) begin
      pend_k <= dir_t'(g_cnt[1:0]);
      if (pend && (rd_data == want_seen)) mask[pend_k] <= 1'b1;
    end

    if (st == ST_PICK) begin
      if (pk.has) begin
        res_x[0]    <= tile_of(base_x, sel_nbr.x);
        res_y[0]    <= tile_of(base_y, sel_nbr.y);
        res_kind[0] <= KIND_WALK;
        res_x[1]    <= tile_of(sel_nbr.x, sel_nbr.x);
        res_y[1]    <= tile_of(sel_nbr.y, sel_nbr.y);
        res_kind[1] <= KIND_WALK;
        res_x[2]    <= tile_of(base_x, base_x);
        res_y[2]    <= tile_of(base_y, base_y);
        res_kind[2] <= KIND_WALK;
        res_last    <= want_seen ? 2'd2 : 2'd1;
      end else if (!want_seen) begin
        scan_x <= '0;
        scan_y <= '0;
      end
    end

    if (adv) begin
      if (scan_last) begin
        res_x[0]    <= tile_of(org_x, org_x);
        res_y[0]    <= tile_of(org_y, org_y);
        res_kind[0] <= KIND_GOAL;
        res_last    <= 2'd0;
      end else if (scan_y == n_cells - 1'b1) begin
        scan_x <= scan_x + 1'b1;
        scan_y <= '0;
      end else begin
        scan_y <= scan_y + 1'b1;
      end
    end

    if (st == ST_SCAN_CHK && !rd_data) begin
      base_x    <= scan_x;
      base_y    <= scan_y;
      want_seen <= 1'b1;
      mask      <= '0;
    end

    if (st == ST_EMIT && out_free) begin
      tile_x      <= res_x[res_idx];
      tile_y      <= res_y[res_idx];
      tile_kind   <= res_kind[res_idx];
      maze_done   <= (res_kind[res_idx] == KIND_GOAL);
      last_of_run <= (res_idx == res_last);
    end
  end

endmodule

### rtl/core/hak_pick.sv
// ----------------------------------------------------------------------------
// Neighbor picker
// Counts candidate neighbors and selects one as random word mod count.
// ----------------------------------------------------------------------------
module hak_pick
  import hak_pkg::*;
(
  input  logic [3:0]        mask,
  input  logic [RAND_W-1:0] rand_value,
  output pick_t             pick
);

  function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
    logic [3:0] s;
    s = 4'(v[0]) + 4'(v[2]) + 4'(v[4]) + 4'(v[6])
      + 4'({v[1], 1'b0}) + 4'({v[3], 1'b0}) + 4'({v[5], 1'b0}) + 4'({v[7], 1'b0});
    if (s >= 4'd9) s = s - 4'd9;
    if (s >= 4'd6) s = s - 4'd6;
    if (s >= 4'd3) s = s - 4'd3;
    return s[1:0];
  endfunction

  logic [2:0] cnt;
  logic [1:0] idx;

  always_comb begin
    cnt = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
  end

  always_comb begin
    case (cnt)
      3'd2:    idx = {1'b0, rand_value[0]};
      3'd3:    idx = mod3(rand_value);
      3'd4:    idx = rand_value[1:0];
      default: idx = 2'd0;
    endcase
  end

  always_comb begin
    logic [1:0] seen_cnt;
    logic       found;
    seen_cnt = 2'd0;
    found    = 1'b0;
    pick.has = (cnt != 3'd0);
    pick.sel = DIR_UP;
    for (int d = 0; d < 4; d++) begin
      if (mask[d] && !found) begin
        if (seen_cnt == idx) begin
          pick.sel = dir_t'(2'(d));
          found    = 1'b1;
        end
        seen_cnt = seen_cnt + 2'd1;
      end
    end
  end

endmodule

### rtl/core/hak_checker.sv
// ----------------------------------------------------------------------------
// Maze generator checker
// Port-level assertions on the tile channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hak_checker
  import hak_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              tile_valid,
  input logic              tile_ready,
  input logic [TILE_W-1:0] tile_x,
  input logic [TILE_W-1:0] tile_y,
  input logic [KIND_W-1:0] tile_kind,
  input logic              maze_done,
  input logic              last_of_run
);

  `HAK_ASSERT_ALWAYS(a_no_item_after_reset, clk, rst |=> !tile_valid, "tile item right after reset")
  `HAK_ASSERT(a_goal_closes_run, clk, rst, tile_valid && maze_done |-> tile_kind == KIND_GOAL && last_of_run, "done flag without final goal item")
  `HAK_ASSERT(a_start_tile, clk, rst, tile_valid && tile_kind == KIND_START |-> tile_x == 5'd1 && tile_y == 5'd1 && last_of_run && !maze_done, "start item not a lone tile at one one")
  `HAK_ASSERT(a_kind_code, clk, rst, tile_valid |-> tile_kind == KIND_WALK || tile_kind == KIND_START || tile_kind == KIND_GOAL, "tile kind code unused")
  `HAK_ASSERT(a_hold_stalled, clk, rst, tile_valid && !tile_ready |=> tile_valid && $stable(tile_x) && $stable(tile_y) && $stable(tile_kind), "stalled tile item changed")

endmodule

bind hunt_and_kill_maze_generator hak_checker u_hak_checker (.*);

### dv/hunt_and_kill_maze_generator_tb.sv
// ----------------------------------------------------------------------------
// Hunt-and-kill maze generator testbench
// Drives start and advance items under random bursts and output stalls across
// many grid sizes, including clamped and mid-maze changes. Each carved tile is
// predicted from a local copy of the visited map and checked in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [hak_pkg::TILE_W-1:0] x;
  logic [hak_pkg::TILE_W-1:0] y;
  logic [hak_pkg::KIND_W-1:0] kind;
  logic                       done;
  logic                       last;
} tile_t;

class maze_tracker;
  bit               visited [hak_pkg::DEF_MAX_SIDE*hak_pkg::DEF_MAX_SIDE];
  int               cur_x;
  int               cur_y;
  int               walk_origin;
  hak_pkg::phase_t  phase;
  logic [hak_pkg::SIDE_W-1:0] side_reg;
  int               cand_x [4];
  int               cand_y [4];
  tile_t            expected_tiles [$];
  int               errors;
  int               tiles_seen;
  int               items;
  int               starts;
  int               steps;
  int               hunts;
  int               goals;
  int               carving_items;

  function new();
    foreach (visited[i]) visited[i] = 0;
    cur_x = 0;
    cur_y = 0;
    walk_origin = 0;
    phase = hak_pkg::PH_IDLE;
    side_reg = hak_pkg::DEF_GRID_SIDE;
  endfunction

  function void set_side(logic [hak_pkg::SIDE_W-1:0] v);
    side_reg = v;
  endfunction

  function int cells_per_side();
    int s;
    s = side_reg;
    if (s < hak_pkg::GRID_SIDE_MIN) s = hak_pkg::GRID_SIDE_MIN;
    if (s > hak_pkg::DEF_MAX_SIDE) s = hak_pkg::DEF_MAX_SIDE;
    return s - 1;
  endfunction

  function int cell_at(int x, int y);
    return (x * hak_pkg::DEF_MAX_SIDE + y) % (hak_pkg::DEF_MAX_SIDE * hak_pkg::DEF_MAX_SIDE);
  endfunction

  function int neighbors(int x, int y, int n, bit want_visited);
    int cnt;
    int nx;
    int ny;
    hak_pkg::dir_t d;
    cnt = 0;
    for (int k = 0; k < 4; k++) begin
      d = hak_pkg::dir_t'(k);
      nx = x;
      ny = y;
      case (d)
        hak_pkg::DIR_UP:    ny = y - 1;
        hak_pkg::DIR_DOWN:  ny = y + 1;
        hak_pkg::DIR_RIGHT: nx = x + 1;
        default:            nx = x - 1;
      endcase
      if (nx >= 0 && ny >= 0 && nx < n && ny < n) begin
        if (visited[cell_at(nx, ny)] == want_visited) begin
          cand_x[cnt] = nx;
          cand_y[cnt] = ny;
          cnt++;
        end
      end
    end
    return cnt;
  endfunction

  function void push_tile(int tx, int ty, logic [hak_pkg::KIND_W-1:0] kind, logic done);
    tile_t t;
    t.x    = hak_pkg::TILE_W'(tx);
    t.y    = hak_pkg::TILE_W'(ty);
    t.kind = kind;
    t.done = done;
    t.last = 1'b0;
    expected_tiles.push_back(t);
  endfunction

  function void note_item(logic f, logic [hak_pkg::RAND_W-1:0] r);
    int  n;
    int  c;
    int  pick;
    int  first;
    bit  found;
    items++;
    n = cells_per_side();
    first = expected_tiles.size();
    if (f == hak_pkg::FUNC_START) begin
      foreach (visited[i]) visited[i] = 0;
      visited[cell_at(0, 0)] = 1;
      cur_x = 0;
      cur_y = 0;
      walk_origin = 0;
      phase = hak_pkg::PH_WALK;
      push_tile(1, 1, hak_pkg::KIND_START, 1'b0);
      starts++;
    end else if (phase == hak_pkg::PH_WALK) begin
      c = neighbors(cur_x, cur_y, n, 1'b0);
      if (c > 0) begin
        pick = int'(r) % c;
        visited[cell_at(cand_x[pick], cand_y[pick])] = 1;
        push_tile(cur_x + cand_x[pick] + 1, cur_y + cand_y[pick] + 1, hak_pkg::KIND_WALK, 1'b0);
        push_tile(2 * cand_x[pick] + 1, 2 * cand_y[pick] + 1, hak_pkg::KIND_WALK, 1'b0);
        cur_x = cand_x[pick];
        cur_y = cand_y[pick];
        steps++;
      end else begin
        found = 0;
        for (int x = 0; x < n; x++) begin
          for (int y = 0; y < n; y++) begin
            if (!found && !visited[cell_at(x, y)]) begin
              c = neighbors(x, y, n, 1'b1);
              if (c > 0) begin
                pick = int'(r) % c;
                push_tile(x + cand_x[pick] + 1, y + cand_y[pick] + 1,
                          hak_pkg::KIND_WALK, 1'b0);
                push_tile(2 * cand_x[pick] + 1, 2 * cand_y[pick] + 1,
                          hak_pkg::KIND_WALK, 1'b0);
                push_tile(2 * x + 1, 2 * y + 1, hak_pkg::KIND_WALK, 1'b0);
                visited[cell_at(x, y)] = 1;
                cur_x = x;
                cur_y = y;
                walk_origin = cell_at(x, y);
                found = 1;
                hunts++;
              end
            end
          end
        end
        if (!found) begin
          push_tile(2 * (walk_origin / hak_pkg::DEF_MAX_SIDE) + 1,
                    2 * (walk_origin % hak_pkg::DEF_MAX_SIDE) + 1, hak_pkg::KIND_GOAL, 1'b1);
          phase = hak_pkg::PH_DONE;
          goals++;
        end
      end
    end
    if (expected_tiles.size() > first) begin
      expected_tiles[$].last = 1'b1;
      carving_items++;
    end
  endfunction

  function void check_tile(tile_t got);
    tile_t want;
    tiles_seen++;
    if (expected_tiles.size() == 0) begin
      $error("unexpected tile x=%0d y=%0d kind=%0d", got.x, got.y, got.kind);
      errors++;
      return;
    end
    want = expected_tiles.pop_front();
    if (got.x !== want.x) begin
      $error("tile_x: expected %0d, actual %0d", want.x, got.x);
      errors++;
    end
    if (got.y !== want.y) begin
      $error("tile_y: expected %0d, actual %0d", want.y, got.y);
      errors++;
    end
    if (got.kind !== want.kind) begin
      $error("tile_kind: expected %0d, actual %0d", want.kind, got.kind);
      errors++;
    end
    if (got.done !== want.done) begin
      $error("maze_done: expected %0d, actual %0d", want.done, got.done);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last_of_run: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module hunt_and_kill_maze_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hak_pkg::*;

  localparam int SETTLE_CYCLES  = 2048;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEM_TARGET    = 210;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIDE_W-1:0] grid_side;
  logic              item_valid;
  logic              item_ready;
  logic              func;
  logic [RAND_W-1:0] rand_value;
  logic              tile_valid;
  logic              tile_ready;
  logic [TILE_W-1:0] tile_x;
  logic [TILE_W-1:0] tile_y;
  logic [KIND_W-1:0] tile_kind;
  logic              maze_done;
  logic              last_of_run;

  maze_tracker tracker = new();
  tile_t       seen_tile;
  int          burst_left;
  int          idle_cycles;
  int          side_writes;

  hunt_and_kill_maze_generator #(
    .MAX_SIDE(DEF_MAX_SIDE)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .grid_side  (grid_side),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .func       (func),
    .rand_value (rand_value),
    .tile_valid (tile_valid),
    .tile_ready (tile_ready),
    .tile_x     (tile_x),
    .tile_y     (tile_y),
    .tile_kind  (tile_kind),
    .maze_done  (maze_done),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int mode;
    int span;
    tile_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       tile_ready = 1'b1;
          1:       tile_ready = ($urandom_range(0, 3) != 0);
          2:       tile_ready = ($urandom_range(0, 4) == 0);
          default: tile_ready = ~tile_ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (item_valid && item_ready) tracker.note_item(func, rand_value);
      if (tile_valid && tile_ready) begin
        seen_tile.x    = tile_x;
        seen_tile.y    = tile_y;
        seen_tile.kind = tile_kind;
        seen_tile.done = maze_done;
        seen_tile.last = last_of_run;
        tracker.check_tile(seen_tile);
      end
      if ((item_valid && item_ready) || (tile_valid && tile_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic f, input logic [RAND_W-1:0] r);
    @(negedge clk);
    if (burst_left == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    burst_left--;
    item_valid = 1'b1;
    func = f;
    rand_value = r;
    do @(posedge clk); while (!item_ready);
  endtask

  // drop valid, wait for all tiles, then let the block settle
  task automatic quiesce();
    @(negedge clk);
    item_valid = 1'b0;
    burst_left = 0;
    while (tracker.expected_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(input logic [SIDE_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    grid_side = v;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_side(v);
    side_writes++;
  endtask

  initial begin
    logic [SIDE_W-1:0] side;
    int                cells;
    int                advances;
    int                choice;
    bit                fresh;
    rst = 1'b1;
    cfg_we = 1'b0;
    grid_side = DEF_GRID_SIDE;
    item_valid = 1'b0;
    func = FUNC_START;
    rand_value = '0;
    burst_left = 0;
    side_writes = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_side(5'd4);
    send_item(FUNC_ADVANCE, 8'hFF);
    send_item(FUNC_START, 8'hA5);
    for (int i = 0; i < 10; i++) send_item(FUNC_ADVANCE, (i % 2) ? 8'hFF : 8'h00);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_ADVANCE, 8'h80);
    send_item(FUNC_ADVANCE, 8'h7F);
    send_item(FUNC_START, 8'hFF);
    quiesce();
    write_side(5'd2);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_ADVANCE, 8'h55);
    send_item(FUNC_ADVANCE, 8'hAA);
    quiesce();
    write_side(5'd16);
    send_item(FUNC_START, 8'h3C);
    send_item(FUNC_ADVANCE, 8'hFF);
    send_item(FUNC_ADVANCE, 8'h00);
    send_item(FUNC_ADVANCE, 8'hC3);

    while (tracker.items < ITEM_TARGET) begin
      quiesce();
      choice = $urandom_range(0, 19);
      case (choice)
        0:       side = 5'd0;
        1:       side = 5'd1;
        2:       side = 5'd31;
        3:       side = 5'd16;
        4:       side = SIDE_W'($urandom_range(17, 30));
        default: side = SIDE_W'($urandom_range(2, 7));
      endcase
      write_side(side);
      cells = tracker.cells_per_side();
      fresh = ($urandom_range(0, 3) != 0);
      if (fresh) send_item(FUNC_START, RAND_W'($urandom));
      advances = (cells > 7) ? $urandom_range(10, 30) : cells * cells + $urandom_range(0, 2);
      for (int i = 0; i < advances; i++) begin
        if ($urandom_range(0, 49) == 0) send_item(FUNC_START, RAND_W'($urandom));
        else send_item(FUNC_ADVANCE, RAND_W'($urandom));
      end
    end

    quiesce();
    $display("Sent %0d items, %0d carving: %0d starts, %0d walk steps, %0d hunts, %0d goals",
             tracker.items, tracker.carving_items, tracker.starts, tracker.steps,
             tracker.hunts, tracker.goals);
    $display("Checked %0d tiles across %0d grid_side writes", tracker.tiles_seen, side_writes);
    if (tracker.errors == 0 && tracker.expected_tiles.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
